// ===== hdl/tcf_pkg.sv =====
package tcf_pkg;

  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned TILT_W    = 24;
  localparam int unsigned ANGLE_W   = 17;
  localparam int unsigned VEC_W     = AXIS_W + 1;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CORD_W    = 36;
  localparam int unsigned Z_W       = 26;
  localparam int unsigned ANG_W     = 18;
  localparam int unsigned GPROD_W   = 33;
  localparam int unsigned GTERM_W   = 25;
  localparam int unsigned SUM_W     = 26;
  localparam int unsigned PROD_W    = 43;
  localparam int unsigned FILT_SH   = 16;
  localparam int unsigned RAW_W     = PROD_W - FILT_SH;
  localparam int unsigned TAB_IDX_W = 5;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic signed [ANG_W-1:0]  HALF_TURN   = 18'sd46080;
  localparam logic signed [Z_W-1:0]    ROUND_HALF  = 26'sd128;
  localparam logic signed [RAW_W-1:0]  TILT_MAX    = 27'sd8388607;
  localparam logic signed [RAW_W-1:0]  TILT_MIN    = -27'sd8388608;

  localparam logic [GAIN_W-1:0] INPUT_GAIN_RST = 16'd1598;
  localparam logic [GAIN_W-1:0] KEEP_GAIN_RST  = 16'd63938;
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 16'd733;

  typedef enum logic [1:0] {
    REG_INPUT_GAIN = 2'd0,
    REG_KEEP_GAIN  = 2'd1,
    REG_GYRO_GAIN  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BASE_NONE,
    BASE_POS,
    BASE_NEG
  } base_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_ANGLE,
    BK_SUM,
    BK_MUL,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic                     zero;
    base_t                    base;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [AXIS_W-1:0] gz;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-i) in degrees, scaled by 65536
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tcf_front.sv =====
module tcf_front (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tcf_pkg::AXIS_W-1:0] in_accel_x,
  input  logic signed [tcf_pkg::AXIS_W-1:0] in_accel_y,
  input  logic signed [tcf_pkg::AXIS_W-1:0] in_gyro_z,
  input  tcf_pkg::q_stat_t                  q_stat,
  output logic                              q_push,
  output tcf_pkg::item_t                    q_item
);
  import tcf_pkg::*;

  logic signed [VEC_W-1:0] ax_ext;
  logic signed [VEC_W-1:0] ay_ext;
  logic                    x_neg;

  assign ax_ext = VEC_W'(in_accel_x);
  assign ay_ext = VEC_W'(in_accel_y);
  assign x_neg  = in_accel_x[AXIS_W-1];

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // fold the left half-plane onto the right and note the base angle
  always_comb begin
    q_item.zero = (in_accel_x == '0) && (in_accel_y == '0);
    q_item.gz   = in_gyro_z;
    if (x_neg) begin
      q_item.x    = -ax_ext;
      q_item.y    = -ay_ext;
      q_item.base = in_accel_y[AXIS_W-1] ? BASE_NEG : BASE_POS;
    end else begin
      q_item.x    = ax_ext;
      q_item.y    = ay_ext;
      q_item.base = BASE_NONE;
    end
  end

endmodule

// ===== hdl/tcf_queue.sv =====
module tcf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcf_pkg::item_t   push_item,
  input  logic             pop,
  output tcf_pkg::item_t   pop_item,
  output tcf_pkg::q_stat_t stat
);
  import tcf_pkg::*;

  localparam int unsigned DEPTH = 2;

  item_t      mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign stat.full  = (count_r == 2'(DEPTH));
  assign stat.empty = (count_r == 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/tcf_back.sv =====
module tcf_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcf_pkg::q_stat_t                   q_stat,
  output logic                               q_pop,
  input  tcf_pkg::item_t                     q_item,
  input  logic [tcf_pkg::GAIN_W-1:0]         input_gain,
  input  logic [tcf_pkg::GAIN_W-1:0]         keep_gain,
  input  logic [tcf_pkg::GAIN_W-1:0]         gyro_gain,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tcf_pkg::TILT_W-1:0]  out_tilt_angle,
  output logic signed [tcf_pkg::ANGLE_W-1:0] out_accel_angle
);
  import tcf_pkg::*;

  localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  back_state_t               state_r;
  back_state_t               state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic [STEP_W-1:0]         step_nxt;
  logic signed [CORD_W-1:0]  x_r;
  logic signed [CORD_W-1:0]  x_nxt;
  logic signed [CORD_W-1:0]  y_r;
  logic signed [CORD_W-1:0]  y_nxt;
  logic signed [Z_W-1:0]     z_r;
  logic signed [Z_W-1:0]     z_nxt;
  base_t                     base_r;
  base_t                     base_nxt;
  logic                      zero_r;
  logic                      zero_nxt;
  logic signed [GPROD_W-1:0] gprod_r;
  logic signed [GPROD_W-1:0] gprod_nxt;
  logic signed [ANGLE_W-1:0] ang_r;
  logic signed [ANGLE_W-1:0] ang_nxt;
  logic signed [GTERM_W-1:0] gterm_r;
  logic signed [GTERM_W-1:0] gterm_nxt;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [PROD_W-1:0]  p_in_r;
  logic signed [PROD_W-1:0]  p_in_nxt;
  logic signed [PROD_W-1:0]  p_keep_r;
  logic signed [PROD_W-1:0]  p_keep_nxt;
  logic signed [TILT_W-1:0]  filt_r;
  logic signed [TILT_W-1:0]  filt_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [TILT_W-1:0]  out_tilt_r;
  logic signed [TILT_W-1:0]  out_tilt_nxt;
  logic signed [ANGLE_W-1:0] out_acc_r;
  logic signed [ANGLE_W-1:0] out_acc_nxt;

  logic signed [CORD_W-1:0]  dx;
  logic signed [CORD_W-1:0]  dy;
  logic signed [Z_W-1:0]     tab;
  logic signed [Z_W-1:0]     z_rnd;
  logic signed [ANG_W-1:0]   base_val;
  logic signed [ANG_W-1:0]   ang_full;
  logic signed [GPROD_W-1:0] gprod_full;
  logic signed [GPROD_W-1:0] gneg;
  logic signed [PROD_W-1:0]  p_sum;
  logic signed [RAW_W-1:0]   filt_raw;
  logic                      slot_free;

  assign dx    = x_r >>> step_r;
  assign dy    = y_r >>> step_r;
  assign tab   = atan_entry(TAB_IDX_W'(step_r));
  assign z_rnd = (z_r + ROUND_HALF) >>> 8;

  always_comb begin
    case (base_r)
      BASE_POS: base_val = HALF_TURN;
      BASE_NEG: base_val = -HALF_TURN;
      default:  base_val = '0;
    endcase
  end

  assign ang_full   = base_val + ANG_W'(z_rnd);
  assign gprod_full = q_item.gz * $signed({1'b0, gyro_gain});
  assign gneg       = -gprod_r;
  assign p_sum      = p_in_r + p_keep_r;
  assign filt_raw   = RAW_W'(p_sum >>> FILT_SH);
  assign slot_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    base_nxt      = base_r;
    zero_nxt      = zero_r;
    gprod_nxt     = gprod_r;
    ang_nxt       = ang_r;
    gterm_nxt     = gterm_r;
    sum_nxt       = sum_r;
    p_in_nxt      = p_in_r;
    p_keep_nxt    = p_keep_r;
    filt_nxt      = filt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tilt_nxt  = out_tilt_r;
    out_acc_nxt   = out_acc_r;
    q_pop         = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          x_nxt     = CORD_W'($signed({q_item.x, FRAC_W'(0)}));
          y_nxt     = CORD_W'($signed({q_item.y, FRAC_W'(0)}));
          z_nxt     = '0;
          base_nxt  = q_item.base;
          zero_nxt  = q_item.zero;
          gprod_nxt = gprod_full;
          step_nxt  = '0;
          state_nxt = BK_ROT;
        end
      end
      BK_ROT: begin
        // rotate towards the x axis, one micro-rotation per cycle
        if (!y_r[CORD_W-1]) begin
          x_nxt = x_r + dy;
          y_nxt = y_r - dx;
          z_nxt = z_r + tab;
        end else begin
          x_nxt = x_r - dy;
          y_nxt = y_r + dx;
          z_nxt = z_r - tab;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = BK_ANGLE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      BK_ANGLE: begin
        if (zero_r) begin
          ang_nxt = '0;
        end else if (ang_full > HALF_TURN) begin
          ang_nxt = ANGLE_W'(HALF_TURN);
        end else if (ang_full < -HALF_TURN) begin
          ang_nxt = ANGLE_W'(-HALF_TURN);
        end else begin
          ang_nxt = ANGLE_W'(ang_full);
        end
        gterm_nxt = GTERM_W'(gneg >>> 8);
        state_nxt = BK_SUM;
      end
      BK_SUM: begin
        sum_nxt   = SUM_W'(ang_r) + SUM_W'(gterm_r);
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        p_in_nxt   = sum_r * $signed({1'b0, input_gain});
        p_keep_nxt = filt_r * $signed({1'b0, keep_gain});
        state_nxt  = BK_EMIT;
      end
      BK_EMIT: begin
        // hold until the output register can take the result
        if (slot_free) begin
          if (filt_raw > TILT_MAX) begin
            filt_nxt = TILT_W'(TILT_MAX);
          end else if (filt_raw < TILT_MIN) begin
            filt_nxt = TILT_W'(TILT_MIN);
          end else begin
            filt_nxt = TILT_W'(filt_raw);
          end
          out_tilt_nxt  = filt_nxt;
          out_acc_nxt   = ang_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    base_r     <= base_nxt;
    zero_r     <= zero_nxt;
    gprod_r    <= gprod_nxt;
    ang_r      <= ang_nxt;
    gterm_r    <= gterm_nxt;
    sum_r      <= sum_nxt;
    p_in_r     <= p_in_nxt;
    p_keep_r   <= p_keep_nxt;
    out_tilt_r <= out_tilt_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tilt_angle  = out_tilt_r;
  assign out_accel_angle = out_acc_r;

endmodule

// ===== hdl/tilt_complementary_filter_top.sv =====
// Tilt estimator. Each input request carries accel x, accel y and gyro z; each
// yields one result: the accelerometer angle atan2(y, x) and the new low-pass
// filtered tilt, both in 1/256 degree. The angle comes from an iterative
// vectoring CORDIC that does one micro-rotation per cycle. The back end loads
// a sample, rotates it through CORDIC_STEPS micro-rotations, then does angle
// rounding, gyro sum, the two gain multiplies and the saturating update of
// the filter state once the output register is free. A two-entry queue in
// front of the CORDIC takes samples while an earlier one is still being worked
// on; the finished result sits in an output register. Gains (input_gain at
// 0x0, keep_gain at 0x4, gyro_gain at 0x8, low 16 bits) come over the APB port;
// the user must write them only while no sample is in flight (unenforced).
module tilt_complementary_filter_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_accel_x,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_accel_y,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_gyro_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tcf_pkg::TILT_W-1:0]  out_tilt_angle,
  output logic signed [tcf_pkg::ANGLE_W-1:0] out_accel_angle,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0]         paddr,
  input  logic [tcf_pkg::DATA_W-1:0]         pwdata,
  output logic [tcf_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tcf_pkg::*;

  logic [GAIN_W-1:0] input_gain_r;
  logic [GAIN_W-1:0] input_gain_nxt;
  logic [GAIN_W-1:0] keep_gain_r;
  logic [GAIN_W-1:0] keep_gain_nxt;
  logic [GAIN_W-1:0] gyro_gain_r;
  logic [GAIN_W-1:0] gyro_gain_nxt;
  logic              wr_en;
  reg_idx_t          reg_idx;
  q_stat_t           q_stat;
  logic              q_push;
  logic              q_pop;
  item_t             push_item;
  item_t             pop_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    input_gain_nxt = input_gain_r;
    keep_gain_nxt  = keep_gain_r;
    gyro_gain_nxt  = gyro_gain_r;
    prdata         = '0;
    case (reg_idx)
      REG_INPUT_GAIN: begin
        prdata = DATA_W'(input_gain_r);
        if (wr_en) begin
          input_gain_nxt = pwdata[GAIN_W-1:0];
        end
      end
      REG_KEEP_GAIN: begin
        prdata = DATA_W'(keep_gain_r);
        if (wr_en) begin
          keep_gain_nxt = pwdata[GAIN_W-1:0];
        end
      end
      REG_GYRO_GAIN: begin
        prdata = DATA_W'(gyro_gain_r);
        if (wr_en) begin
          gyro_gain_nxt = pwdata[GAIN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_gain_r <= INPUT_GAIN_RST;
      keep_gain_r  <= KEEP_GAIN_RST;
      gyro_gain_r  <= GYRO_GAIN_RST;
    end else begin
      input_gain_r <= input_gain_nxt;
      keep_gain_r  <= keep_gain_nxt;
      gyro_gain_r  <= gyro_gain_nxt;
    end
  end

  tcf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_gyro_z  (in_gyro_z),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  tcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  tcf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .q_item          (pop_item),
    .input_gain      (input_gain_r),
    .keep_gain       (keep_gain_r),
    .gyro_gain       (gyro_gain_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tilt_angle  (out_tilt_angle),
    .out_accel_angle (out_accel_angle)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accel_angle <= 17'sd46080 && out_accel_angle >= -17'sd46080))
    else $error("accel angle beyond half turn");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");
`endif

endmodule

// ===== dv/tilt_filter_checker.sv =====
`timescale 1ns / 1ps

module tilt_filter_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_accel_x,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_accel_y,
  input  logic signed [tcf_pkg::AXIS_W-1:0]  in_gyro_z,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [tcf_pkg::TILT_W-1:0]  out_tilt_angle,
  input  logic signed [tcf_pkg::ANGLE_W-1:0] out_accel_angle,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [tcf_pkg::ADDR_W-1:0]         paddr,
  input  logic [tcf_pkg::DATA_W-1:0]         pwdata,
  output int                                 open_count,
  output int                                 result_count,
  output int                                 fail_count
);

  localparam longint HALF_TURN_256 = 46080;
  localparam longint TILT_HI       = 8388607;
  localparam longint TILT_LO       = -8388608;
  localparam int     LUT_LEN       = 24;

  typedef struct packed {
    logic signed [tcf_pkg::TILT_W-1:0]  tilt;
    logic signed [tcf_pkg::ANGLE_W-1:0] angle;
  } tilt_result_t;

  // atan(2^-i) in 1/65536 degree
  longint atan_lut [0:LUT_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [tcf_pkg::GAIN_W-1:0]       input_gain;
  logic [tcf_pkg::GAIN_W-1:0]       keep_gain;
  logic [tcf_pkg::GAIN_W-1:0]       gyro_gain;
  logic signed [tcf_pkg::TILT_W-1:0] filtered_tilt;
  tilt_result_t                     pending_results [$];
  int                               mismatches;
  int                               compared;

  function automatic logic signed [tcf_pkg::ANGLE_W-1:0] accel_angle_of(
    input logic signed [tcf_pkg::AXIS_W-1:0] ax,
    input logic signed [tcf_pkg::AXIS_W-1:0] ay
  );
    longint x, y, z, dx, dy, base, ang;
    x = ax;
    y = ay;
    z = 0;
    base = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane: rotate by half a turn first
    if (x < 0) begin
      base = (y >= 0) ? HALF_TURN_256 : -HALF_TURN_256;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < LUT_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end
    end
    ang = base + ((z + 128) >>> 8);
    if (ang > HALF_TURN_256) ang = HALF_TURN_256;
    if (ang < -HALF_TURN_256) ang = -HALF_TURN_256;
    return tcf_pkg::ANGLE_W'(ang);
  endfunction

  function automatic logic signed [tcf_pkg::TILT_W-1:0] next_tilt(
    input logic signed [tcf_pkg::ANGLE_W-1:0] angle,
    input logic signed [tcf_pkg::AXIS_W-1:0]  gz
  );
    longint gz_l, ig_l, kg_l, gg_l, state_l, gterm, sum, mix, nxt;
    gz_l = gz;
    ig_l = input_gain;
    kg_l = keep_gain;
    gg_l = gyro_gain;
    state_l = filtered_tilt;
    gterm = (-(gz_l * gg_l)) >>> 8;
    sum = longint'(angle) + gterm;
    mix = ig_l * sum + kg_l * state_l;
    nxt = mix >>> 16;
    if (nxt > TILT_HI) nxt = TILT_HI;
    if (nxt < TILT_LO) nxt = TILT_LO;
    return tcf_pkg::TILT_W'(nxt);
  endfunction

  always @(posedge clk) begin
    tilt_result_t seen, want;
    if (!rst_n) begin
      input_gain = tcf_pkg::INPUT_GAIN_RST;
      keep_gain = tcf_pkg::KEEP_GAIN_RST;
      gyro_gain = tcf_pkg::GYRO_GAIN_RST;
      filtered_tilt = '0;
      pending_results.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (tcf_pkg::reg_idx_t'(paddr[3:2]))
          tcf_pkg::REG_INPUT_GAIN: input_gain = pwdata[tcf_pkg::GAIN_W-1:0];
          tcf_pkg::REG_KEEP_GAIN:  keep_gain = pwdata[tcf_pkg::GAIN_W-1:0];
          tcf_pkg::REG_GYRO_GAIN:  gyro_gain = pwdata[tcf_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen.tilt = out_tilt_angle;
        seen.angle = out_accel_angle;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing outstanding, tilt_angle %0d accel_angle %0d",
                   $time, seen.tilt, seen.angle);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compared++;
          if (seen.tilt !== want.tilt) begin
            $display("%0t: tilt_angle expected %0d, got %0d", $time, want.tilt, seen.tilt);
            mismatches++;
          end
          if (seen.angle !== want.angle) begin
            $display("%0t: accel_angle expected %0d, got %0d", $time, want.angle, seen.angle);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want.angle = accel_angle_of(in_accel_x, in_accel_y);
        want.tilt = next_tilt(want.angle, in_gyro_z);
        filtered_tilt = want.tilt;
        pending_results.push_back(want);
      end
    end
    open_count <= pending_results.size();
    result_count <= compared;
    fail_count <= mismatches;
  end

endmodule

// ===== dv/tilt_complementary_filter_top_tb.sv =====
`timescale 1ns / 1ps

module tilt_complementary_filter_top_tb;

  localparam int unsigned STEPS  = 16;
  localparam int          SETTLE = STEPS + 24;

  localparam logic signed [tcf_pkg::AXIS_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [tcf_pkg::AXIS_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [tcf_pkg::AXIS_W-1:0]   in_accel_x;
  logic signed [tcf_pkg::AXIS_W-1:0]   in_accel_y;
  logic signed [tcf_pkg::AXIS_W-1:0]   in_gyro_z;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [tcf_pkg::TILT_W-1:0]   out_tilt_angle;
  logic signed [tcf_pkg::ANGLE_W-1:0]  out_accel_angle;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [tcf_pkg::ADDR_W-1:0]          paddr;
  logic [tcf_pkg::DATA_W-1:0]          pwdata;
  logic [tcf_pkg::DATA_W-1:0]          prdata;
  logic                                pready;

  int   open_count;
  int   result_count;
  int   fail_count;
  int   samples_sent;
  int   gain_settings;
  bit   idle_on;

  tilt_complementary_filter_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_gyro_z(in_gyro_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tilt_angle(out_tilt_angle), .out_accel_angle(out_accel_angle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tilt_filter_checker #(.CORDIC_STEPS(STEPS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_gyro_z(in_gyro_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tilt_angle(out_tilt_angle), .out_accel_angle(out_accel_angle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .open_count(open_count), .result_count(result_count), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic signed [tcf_pkg::AXIS_W-1:0] ax,
                             input logic signed [tcf_pkg::AXIS_W-1:0] ay,
                             input logic signed [tcf_pkg::AXIS_W-1:0] gz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_gyro_z <= gz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic signed [tcf_pkg::AXIS_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return '0;
    endcase
  endfunction

  task automatic send_random_sample();
    logic signed [tcf_pkg::AXIS_W-1:0] ax, ay, gz;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        ax = 16'($urandom);
        ay = 16'($urandom);
        gz = 16'($urandom);
      end
      3, 4: begin
        // near the origin, where quadrant handling matters most
        ax = 16'(int'($urandom_range(0, 64)) - 32);
        ay = 16'(int'($urandom_range(0, 64)) - 32);
        gz = 16'(int'($urandom_range(0, 64)) - 32);
      end
      5: begin
        // roughly upright platform: gravity on x, small lean, slow rotation
        ax = 16'(16384 + int'($urandom_range(0, 2048)) - 1024);
        if ($urandom_range(0, 1)) ax = -ax;
        ay = 16'(int'($urandom_range(0, 8192)) - 4096);
        gz = 16'(int'($urandom_range(0, 1024)) - 512);
      end
      6: begin
        ax = $urandom_range(0, 1) ? 16'($urandom) : '0;
        ay = (ax == 0) ? 16'($urandom) : '0;
        gz = 16'($urandom);
      end
      7: begin
        ax = edge_value();
        ay = edge_value();
        gz = edge_value();
      end
      default: begin
        ax = 16'($urandom);
        ay = 16'($urandom);
        gz = edge_value();
      end
    endcase
    send_sample(ax, ay, gz);
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [tcf_pkg::GAIN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // upper data bits carry junk that must be dropped
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [tcf_pkg::GAIN_W-1:0] ig,
                           input logic [tcf_pkg::GAIN_W-1:0] kg,
                           input logic [tcf_pkg::GAIN_W-1:0] gg,
                           input int n_samples);
    write_gain(tcf_pkg::REG_INPUT_GAIN, ig);
    write_gain(tcf_pkg::REG_KEEP_GAIN, kg);
    write_gain(tcf_pkg::REG_GYRO_GAIN, gg);
    gain_settings++;
    repeat (n_samples) send_random_sample();
    drain();
  endtask

  initial begin
    logic [tcf_pkg::GAIN_W-1:0] ig;
    idle_on = 1'b1;
    samples_sent = 0;
    gain_settings = 1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_accel_x <= '0;
    in_accel_y <= '0;
    in_gyro_z <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: axes, quadrant boundaries, half-turn clamp, gyro extremes
    send_sample('0, '0, '0);
    send_sample(S_MAX, '0, '0);
    send_sample(S_MIN, '0, '0);
    send_sample('0, S_MAX, '0);
    send_sample('0, S_MIN, '0);
    send_sample(S_MIN, -16'sd1, '0);
    send_sample(S_MIN, 16'sd1, '0);
    send_sample(-16'sd1, '0, '0);
    send_sample(-16'sd5, '0, '0);
    send_sample(S_MIN, S_MIN, '0);
    send_sample(S_MAX, S_MAX, '0);
    send_sample(S_MAX, S_MIN, '0);
    send_sample(S_MIN, S_MAX, '0);
    send_sample(16'sd1, -16'sd1, '0);
    send_sample(-16'sd1, -16'sd1, '0);
    send_sample('0, '0, S_MAX);
    send_sample('0, '0, S_MIN);
    send_sample('0, '0, -16'sd1);
    send_sample(16'sd16384, '0, S_MAX);
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
    send_sample(S_MIN, '0, S_MIN);
    drain();

    // full gains drive the state into both saturation limits
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 200);
    // zero gains; a write past the last register must change nothing
    write_gain(REG_UNMAPPED, 16'($urandom));
    run_phase(16'h0000, 16'h0000, 16'h0000, 150);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 150);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, 150);
    repeat (5) begin
      ig = 16'($urandom);
      if ($urandom_range(0, 1))
        run_phase(ig, 16'(17'h10000 - ig), 16'($urandom), 200);
      else
        run_phase(ig, 16'($urandom), 16'($urandom), 200);
    end
    // back to the reset gains, both sides flat out
    idle_on = 1'b0;
    run_phase(tcf_pkg::INPUT_GAIN_RST, tcf_pkg::KEEP_GAIN_RST, tcf_pkg::GYRO_GAIN_RST, 300);

    $display("Sent %0d samples over %0d gain settings, including saturation and clamp cases.",
             samples_sent, gain_settings);
    $display("Compared %0d results field by field, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
